// File: sv/pinned_lru_handle_pool_defines.svh
// Assertion helpers for the checker file.
`ifndef PINNED_LRU_HANDLE_POOL_DEFINES_SVH
`define PINNED_LRU_HANDLE_POOL_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst is high
`define PLHP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst is high
`define PLHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/plhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plhp_pkg;

  localparam int ENTRIES  = 64;
  localparam int ENTRY_W  = $clog2(ENTRIES);
  localparam int REF_W    = 8;
  localparam int STAMP_W  = 32;
  localparam int COUNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W   = REF_W + STAMP_W;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

  localparam logic [REF_W-1:0]   REF_MAX      = {REF_W{1'b1}};
  localparam logic [COUNT_W-1:0] MAX_OPEN_RST = COUNT_W'(ENTRIES);

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_ALLOCATE = 2'd1,
    ACT_RELEASE  = 2'd2,
    ACT_REMOVE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_EVICT  = 3'd1,
    ST_OPEN_FAIL = 3'd2,
    ST_NOT_REG   = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted request
    logic capture;     // latch the requested entry's memory word
    logic scan_clear;  // restart the eviction search
    logic scan_rd;     // read the next entry of the search
    logic apply;       // commit the update and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/plhp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface plhp_req_if;
  logic                          valid;
  logic                          ready;
  logic [plhp_pkg::ACTION_W-1:0] action;
  logic [plhp_pkg::ENTRY_W-1:0]  entry;
  logic                          open_ok;

  modport source (output valid, action, entry, open_ok, input ready);
  modport sink   (input valid, action, entry, open_ok, output ready);
endinterface

// Response channel
interface plhp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [plhp_pkg::STATUS_W-1:0] status;
  logic                          evicted_valid;
  logic [plhp_pkg::ENTRY_W-1:0]  evicted_entry;
  logic [plhp_pkg::COUNT_W-1:0]  open_count;
  logic                          entry_open;
  logic [plhp_pkg::REF_W-1:0]    entry_refs;

  modport source (output valid, status, evicted_valid, evicted_entry, open_count,
                  entry_open, entry_refs, input ready);
  modport sink   (input valid, status, evicted_valid, evicted_entry, open_count,
                  entry_open, entry_refs, output ready);
endinterface

`default_nettype wire

// File: sv/pinned_lru_handle_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Handshake          Contents
// req         in   valid/ready        action, entry, open_ok
// rsp         out  valid/ready        status, evicted_valid/entry, open_count,
//                                     entry_open, entry_refs
// cfg         in   cfg_we only        max_open (cfg_wdata)
//
// One transaction at a time. Without an eviction search a request passes READ, EVAL and
// APPLY (which waits for a free result register) and the next one is taken back in IDLE;
// an allocate that needs an eviction adds SCAN and DRAIN, as the search reads one entry
// per cycle through the count/stamp memory's read port.
// Reset clears all marks and counters; no clearing pass is needed.
// A result waiting on rsp does not block acceptance of the next request; the
// block stalls only before committing that request's update.

module pinned_lru_handle_pool (
  input  wire logic                         clk,
  input  wire logic                         rst,
  plhp_req_if.sink                          req,
  plhp_rsp_if.source                        rsp,
  input  wire logic                         cfg_we,
  input  wire logic [plhp_pkg::COUNT_W-1:0] cfg_wdata
);

  plhp_pkg::ctrl_cmd_t cmd;
  plhp_pkg::dp_stat_t  stat;

  plhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plhp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (req.action),
    .in_entry   (req.entry),
    .in_open_ok (req.open_ok),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// File: sv/plhp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module plhp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire plhp_pkg::dp_stat_t  stat,
  output plhp_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_DRAIN,
    S_APPLY
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands from the current state
  always_comb begin
    cmd            = '0;
    cmd.load       = req_valid && req_ready;
    cmd.capture    = (state == S_EVAL);
    cmd.scan_clear = (state == S_EVAL);
    cmd.scan_rd    = (state == S_SCAN);
    cmd.apply      = (state == S_APPLY) && stat.out_free;
  end

  // Sequence one transaction at a time
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = stat.need_scan ? S_SCAN : S_APPLY;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: sv/plhp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module plhp_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire plhp_pkg::ctrl_cmd_t                 cmd,
  output plhp_pkg::dp_stat_t                       stat,
  input  wire logic [plhp_pkg::ACTION_W-1:0]       in_action,
  input  wire logic [plhp_pkg::ENTRY_W-1:0]        in_entry,
  input  wire logic                                in_open_ok,
  input  wire logic                                cfg_we,
  input  wire logic [plhp_pkg::COUNT_W-1:0]        cfg_wdata,
  plhp_rsp_if.source                               rsp
);

  // Request latch
  plhp_pkg::action_t                 req_action;
  logic [plhp_pkg::ENTRY_W-1:0]      req_entry;
  logic                              req_ok;

  // Per-entry flags in flops, count and stamp in a memory
  logic [plhp_pkg::ENTRIES-1:0]      entry_valid;
  logic [plhp_pkg::ENTRIES-1:0]      entry_is_open;
  logic [plhp_pkg::ENTRIES-1:0]      entry_is_open_next;
  logic [plhp_pkg::WORD_W-1:0]       mem [plhp_pkg::ENTRIES];
  logic [plhp_pkg::WORD_W-1:0]       rd_q;
  logic [plhp_pkg::ENTRY_W-1:0]      rd_addr;
  logic [plhp_pkg::REF_W-1:0]        rd_ref;
  logic [plhp_pkg::STAMP_W-1:0]      rd_stamp;

  // Requested entry's word, zero when unregistered
  logic [plhp_pkg::REF_W-1:0]        cur_ref;
  logic [plhp_pkg::STAMP_W-1:0]      cur_stamp;

  // Eviction search
  logic [plhp_pkg::ENTRY_W-1:0]      scan_idx;
  logic [plhp_pkg::ENTRY_W-1:0]      cmp_idx;
  logic                              cmp_pending;
  logic                              found;
  logic [plhp_pkg::ENTRY_W-1:0]      best_idx;
  logic [plhp_pkg::STAMP_W-1:0]      best_age;
  logic [plhp_pkg::STAMP_W-1:0]      age;
  logic                              cand;

  // Global state
  logic [plhp_pkg::COUNT_W-1:0]      open_total;
  logic [plhp_pkg::STAMP_W-1:0]      stamp_counter;
  logic [plhp_pkg::COUNT_W-1:0]      max_open;

  // Update decode
  logic                              valid_i;
  logic                              open_i;
  logic                              cap_hit;
  plhp_pkg::status_t                 nx_status;
  logic                              evict;
  logic                              open_new;
  logic                              close_i;
  logic                              set_valid;
  logic                              clr_valid;
  logic                              wr_en;
  logic [plhp_pkg::REF_W-1:0]        wr_ref;
  logic [plhp_pkg::STAMP_W-1:0]      wr_stamp;
  logic                              adv_stamp;
  logic [plhp_pkg::REF_W-1:0]        ref_inc;
  logic [plhp_pkg::REF_W-1:0]        e_refs;
  logic                              e_open;
  logic [plhp_pkg::COUNT_W-1:0]      total_next;

  // Output register
  logic                              out_valid;
  plhp_pkg::status_t                 out_status;
  logic                              out_ev_valid;
  logic [plhp_pkg::ENTRY_W-1:0]      out_ev_entry;
  logic [plhp_pkg::COUNT_W-1:0]      out_count;
  logic                              out_open;
  logic [plhp_pkg::REF_W-1:0]        out_refs;

  assign valid_i  = entry_valid[req_entry];
  assign open_i   = entry_is_open[req_entry];
  assign cap_hit  = (open_total >= max_open);
  assign rd_ref   = rd_q[plhp_pkg::WORD_W-1 -: plhp_pkg::REF_W];
  assign rd_stamp = rd_q[plhp_pkg::STAMP_W-1:0];
  assign rd_addr  = cmd.scan_rd ? scan_idx : req_entry;

  assign stat.need_scan = (req_action == plhp_pkg::ACT_ALLOCATE) && valid_i && !open_i
                          && cap_hit;
  assign stat.scan_last = (scan_idx == plhp_pkg::ENTRY_W'(plhp_pkg::ENTRIES - 1));
  assign stat.out_free  = !out_valid || rsp.ready;

  // Latch the request and the configuration register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= plhp_pkg::action_t'(in_action);
      req_entry  <= in_entry;
      req_ok     <= in_open_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_open <= plhp_pkg::MAX_OPEN_RST;
    end else if (cfg_we) begin
      max_open <= cfg_wdata;
    end
  end

  // Count/stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req_entry] <= {wr_ref, wr_stamp};
    end
    rd_q <= mem[rd_addr];
  end

  // Capture the requested entry's word, masked by its registered mark
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_ref   <= valid_i ? rd_ref : '0;
      cur_stamp <= valid_i ? rd_stamp : '0;
    end
  end

  // Search: one entry read per cycle, compared in the cycle after its read
  assign age  = stamp_counter - rd_stamp;
  assign cand = entry_valid[cmp_idx] && entry_is_open[cmp_idx] && (rd_ref == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pending <= 1'b0;
      found       <= 1'b0;
      scan_idx    <= '0;
    end else if (cmd.scan_clear) begin
      cmp_pending <= 1'b0;
      found       <= 1'b0;
      scan_idx    <= '0;
    end else begin
      cmp_pending <= cmd.scan_rd;
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_pending && cand && (!found || (age > best_age))) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      cmp_idx <= scan_idx;
    end
    if (cmp_pending && cand && (!found || (age > best_age))) begin
      best_idx <= cmp_idx;
      best_age <= age;
    end
  end

  // Decode the update of the requested entry
  assign ref_inc = (cur_ref == plhp_pkg::REF_MAX) ? cur_ref : cur_ref + 1'b1;

  always_comb begin
    nx_status = plhp_pkg::ST_OK;
    evict     = 1'b0;
    open_new  = 1'b0;
    close_i   = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr_en     = 1'b0;
    wr_ref    = '0;
    wr_stamp  = '0;
    adv_stamp = 1'b0;
    e_refs    = cur_ref;
    case (req_action)
      plhp_pkg::ACT_REGISTER: begin
        close_i   = open_i;
        set_valid = 1'b1;
        wr_en     = cmd.apply;
        e_refs    = '0;
      end
      plhp_pkg::ACT_ALLOCATE: begin
        if (!valid_i) begin
          nx_status = plhp_pkg::ST_NOT_REG;
        end else if (!open_i && cap_hit && !found) begin
          nx_status = plhp_pkg::ST_NO_EVICT;
        end else begin
          evict = !open_i && cap_hit;
          if (!open_i && !req_ok) begin
            nx_status = plhp_pkg::ST_OPEN_FAIL;
          end else begin
            open_new  = !open_i;
            wr_en     = cmd.apply;
            wr_ref    = ref_inc;
            wr_stamp  = stamp_counter;
            adv_stamp = 1'b1;
            e_refs    = ref_inc;
            nx_status = (cur_ref == plhp_pkg::REF_MAX) ? plhp_pkg::ST_OVERFLOW
                                                       : plhp_pkg::ST_OK;
          end
        end
      end
      plhp_pkg::ACT_RELEASE: begin
        if (!valid_i) begin
          nx_status = plhp_pkg::ST_NOT_REG;
        end else if (cur_ref == '0) begin
          nx_status = plhp_pkg::ST_UNDERFLOW;
        end else begin
          wr_en    = cmd.apply;
          wr_ref   = cur_ref - 1'b1;
          wr_stamp = cur_stamp;
          e_refs   = cur_ref - 1'b1;
        end
      end
      plhp_pkg::ACT_REMOVE: begin
        if (!valid_i) begin
          nx_status = plhp_pkg::ST_NOT_REG;
        end else begin
          close_i   = open_i;
          clr_valid = 1'b1;
          wr_en     = cmd.apply;
          e_refs    = '0;
        end
      end
      default: begin
        nx_status = plhp_pkg::ST_NOT_REG;
      end
    endcase
  end

  assign e_open     = (open_i && !close_i) || open_new;
  assign total_next = open_total + plhp_pkg::COUNT_W'(open_new)
                      - plhp_pkg::COUNT_W'(close_i || evict);

  // Merge the victim close and the requested entry's open/close into one update
  always_comb begin
    entry_is_open_next = entry_is_open;
    if (evict)    entry_is_open_next[best_idx]  = 1'b0;
    if (close_i)  entry_is_open_next[req_entry] = 1'b0;
    if (open_new) entry_is_open_next[req_entry] = 1'b1;
  end

  // Commit flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      entry_is_open <= '0;
      open_total    <= '0;
      stamp_counter <= '0;
    end else if (cmd.apply) begin
      if (set_valid) entry_valid[req_entry] <= 1'b1;
      if (clr_valid) entry_valid[req_entry] <= 1'b0;
      entry_is_open <= entry_is_open_next;
      open_total <= total_next;
      if (adv_stamp) stamp_counter <= stamp_counter + 1'b1;
    end
  end

  // Load the result register, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_status   <= nx_status;
      out_ev_valid <= evict;
      out_ev_entry <= evict ? best_idx : '0;
      out_count    <= total_next;
      out_open     <= e_open;
      out_refs     <= e_refs;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.evicted_valid = out_ev_valid;
  assign rsp.evicted_entry = out_ev_entry;
  assign rsp.open_count    = out_count;
  assign rsp.entry_open    = out_open;
  assign rsp.entry_refs    = out_refs;

endmodule

`default_nettype wire

// File: sv/plhp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pinned_lru_handle_pool_defines.svh"

module plhp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [plhp_pkg::STATUS_W-1:0] rsp_status,
  input wire logic                          rsp_evicted_valid,
  input wire logic [plhp_pkg::ENTRY_W-1:0]  rsp_evicted_entry,
  input wire logic [plhp_pkg::COUNT_W-1:0]  rsp_open_count,
  input wire logic                          rsp_entry_open,
  input wire logic [plhp_pkg::REF_W-1:0]    rsp_entry_refs
);

  // Open count never exceeds the table size
  `PLHP_ASSERT_SAME(a_count_range, rsp_valid, rsp_open_count <= plhp_pkg::COUNT_W'(plhp_pkg::ENTRIES), "open_count above table size")

  // An eviction only comes with a request that got past the search
  `PLHP_ASSERT_SAME(a_evict_status, rsp_valid && rsp_evicted_valid, rsp_status == plhp_pkg::ST_OK || rsp_status == plhp_pkg::ST_OPEN_FAIL || rsp_status == plhp_pkg::ST_OVERFLOW, "eviction with wrong status")

  // An unregistered entry is always closed with no references
  `PLHP_ASSERT_SAME(a_unreg_clear, rsp_valid && rsp_status == plhp_pkg::ST_NOT_REG, !rsp_entry_open && rsp_entry_refs == '0 && !rsp_evicted_valid, "unregistered entry shows state")

  // A stalled result holds
  `PLHP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_evicted_entry) && $stable(rsp_open_count) && $stable(rsp_entry_refs), "stalled result changed")

endmodule

bind pinned_lru_handle_pool plhp_checker u_plhp_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_evicted_valid (rsp.evicted_valid),
  .rsp_evicted_entry (rsp.evicted_entry),
  .rsp_open_count    (rsp.open_count),
  .rsp_entry_open    (rsp.entry_open),
  .rsp_entry_refs    (rsp.entry_refs)
);

`default_nettype wire
